@@ hdl/crtc_pkg.sv @@
// Shared types, field widths, codes and calendar helpers for the
// calendar real-time clock. No dependencies.
package crtc_pkg;

   localparam int KIND_W   = 2;
   localparam int RAW_W    = 8;
   localparam int YEAR_W   = 8;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int MILLI_W  = 10;
   localparam int PERIOD_W = 10;

   localparam int YEAR_SPAN  = 1 << YEAR_W;
   localparam int MONTHS     = 12;
   localparam int HOURS      = 24;
   localparam int MINUTES    = 60;
   localparam int SECONDS    = 60;
   localparam int MS_PER_SEC = 1000;

   localparam int YEAR_BASE_DEFAULT = 2000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK = 2'd0,
      KIND_GET  = 2'd1,
      KIND_SET  = 2'd2
   } kind_type;

   typedef enum logic [KIND_W-1:0] {
      REPORT_PERIODIC = 2'd0,
      REPORT_GET      = 2'd1,
      REPORT_SET      = 2'd2
   } report_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [RAW_W-1:0]  set_year_offset;
      logic [RAW_W-1:0]  set_month;
      logic [RAW_W-1:0]  set_day;
      logic [RAW_W-1:0]  set_hour;
      logic [RAW_W-1:0]  set_minute;
      logic [RAW_W-1:0]  set_second;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]   report_kind;
      logic [YEAR_W-1:0]   year_offset;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic                set_ok;
      logic                interrupt;
   } rsp_item_type;

   typedef struct packed {
      logic         has_result;
      rsp_item_type item;
   } core_out_type;

   // Leap flag for each year offset, built at elaboration from the base year.
   function automatic logic [YEAR_SPAN-1:0] leap_table(int base);
      int y;
      logic [YEAR_SPAN-1:0] t;
      t = '0;
      for (int i = 0; i < YEAR_SPAN; i++) begin
         y = base + i;
         t[i] = ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
      end
      return t;
   endfunction

   // Length of a month; out-of-range codes read as 31.
   function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] mon, logic leap);
      logic [DAY_W-1:0] d;
      case (mon)
         4'd2:                      d = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11:   d = DAY_W'(30);
         default:                   d = DAY_W'(31);
      endcase
      return d;
   endfunction

endpackage

@@ hdl/crtc_channels.sv @@
// Valid/ready channel interfaces of the calendar real-time clock.
// Depends on crtc_pkg for field widths.
interface crtc_req_if import crtc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [RAW_W-1:0]    set_year_offset;
   logic [RAW_W-1:0]    set_month;
   logic [RAW_W-1:0]    set_day;
   logic [RAW_W-1:0]    set_hour;
   logic [RAW_W-1:0]    set_minute;
   logic [RAW_W-1:0]    set_second;
   modport source (output valid, kind, set_year_offset, set_month, set_day,
                   set_hour, set_minute, set_second, input ready);
   modport sink   (input valid, kind, set_year_offset, set_month, set_day,
                   set_hour, set_minute, set_second, output ready);
endinterface

interface crtc_rsp_if import crtc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   report_kind;
   logic [YEAR_W-1:0]   year_offset;
   logic [MONTH_W-1:0]  month;
   logic [DAY_W-1:0]    day;
   logic [HOUR_W-1:0]   hour;
   logic [MINUTE_W-1:0] minute;
   logic [SECOND_W-1:0] second;
   logic                set_ok;
   logic                interrupt;
   modport source (output valid, report_kind, year_offset, month, day, hour,
                   minute, second, set_ok, interrupt, input ready);
   modport sink   (input valid, report_kind, year_offset, month, day, hour,
                   minute, second, set_ok, interrupt, output ready);
endinterface

interface crtc_csr_if import crtc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] interrupt_period_ms;
   modport source (output valid, interrupt_period_ms, input ready);
   modport sink   (input valid, interrupt_period_ms, output ready);
endinterface

@@ hdl/crtc_set_check.sv @@
// Validity check of a requested date and time.
// Depends on crtc_pkg (widths, month_days).
module crtc_set_check import crtc_pkg::*; (
   input  logic [RAW_W-1:0] set_month,
   input  logic [RAW_W-1:0] set_day,
   input  logic [RAW_W-1:0] set_hour,
   input  logic [RAW_W-1:0] set_minute,
   input  logic [RAW_W-1:0] set_second,
   input  logic             leap,
   output logic             ok
);
   logic             month_ok;
   logic [DAY_W-1:0] limit;

   assign month_ok = (set_month >= RAW_W'(1)) && (set_month <= RAW_W'(MONTHS));
   // only meaningful when month_ok; the low nibble then is the month
   assign limit    = month_days(set_month[MONTH_W-1:0], leap);

   assign ok = month_ok
            && (set_day >= RAW_W'(1)) && (set_day <= RAW_W'(limit))
            && (set_hour < RAW_W'(HOURS))
            && (set_minute < RAW_W'(MINUTES))
            && (set_second < RAW_W'(SECONDS));
endmodule

@@ hdl/crtc_time_core.sv @@
// Date/time state, millisecond and period counters, carry chain and set load.
// Depends on crtc_pkg and crtc_set_check.
module crtc_time_core import crtc_pkg::*; #(
   parameter int YEAR_BASE = YEAR_BASE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  req_item_type        item,
   input  logic [PERIOD_W-1:0] period,
   output core_out_type        result
);
   localparam logic [YEAR_SPAN-1:0] LeapTab = leap_table(YEAR_BASE);

   logic [YEAR_W-1:0]   year_ff,   year_in;
   logic [MONTH_W-1:0]  month_ff,  month_in;
   logic [DAY_W-1:0]    day_ff,    day_in;
   logic [HOUR_W-1:0]   hour_ff,   hour_in;
   logic [MINUTE_W-1:0] minute_ff, minute_in;
   logic [SECOND_W-1:0] second_ff, second_in;
   logic [MILLI_W-1:0]  milli_ff,  milli_in;
   logic [PERIOD_W-1:0] pcount_ff, pcount_in;

   logic [PERIOD_W-1:0] period_eff;
   logic [PERIOD_W:0]   pcount_sum;
   logic                period_hit;
   logic                sec_tick;
   logic                sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
   logic [DAY_W-1:0]    cur_days;
   logic                set_ok;

   crtc_set_check u_set_check (
      .set_month  (item.set_month),
      .set_day    (item.set_day),
      .set_hour   (item.set_hour),
      .set_minute (item.set_minute),
      .set_second (item.set_second),
      .leap       (LeapTab[item.set_year_offset]),
      .ok         (set_ok)
   );

   // a zero period behaves as one
   assign period_eff = (period == '0) ? PERIOD_W'(1) : period;
   assign pcount_sum = {1'b0, pcount_ff} + (PERIOD_W+1)'(1);
   assign period_hit = pcount_sum >= {1'b0, period_eff};

   assign sec_tick   = milli_ff >= MILLI_W'(MS_PER_SEC - 1);
   assign cur_days   = month_days(month_ff, LeapTab[year_ff]);
   assign sec_wrap   = second_ff >= SECOND_W'(SECONDS - 1);
   assign min_wrap   = minute_ff >= MINUTE_W'(MINUTES - 1);
   assign hour_wrap  = hour_ff >= HOUR_W'(HOURS - 1);
   assign day_wrap   = day_ff >= cur_days;
   assign month_wrap = month_ff >= MONTH_W'(MONTHS);

   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      milli_in  = milli_ff;
      pcount_in = pcount_ff;
      result.has_result = 1'b0;
      case (item.kind)
         KIND_TICK: begin
            result.has_result = period_hit;
            pcount_in = period_hit ? '0 : pcount_sum[PERIOD_W-1:0];
            milli_in  = sec_tick ? '0 : milli_ff + MILLI_W'(1);
            if (sec_tick) begin
               second_in = sec_wrap ? '0 : second_ff + SECOND_W'(1);
               if (sec_wrap) begin
                  minute_in = min_wrap ? '0 : minute_ff + MINUTE_W'(1);
                  if (min_wrap) begin
                     hour_in = hour_wrap ? '0 : hour_ff + HOUR_W'(1);
                     if (hour_wrap) begin
                        day_in = day_wrap ? DAY_W'(1) : day_ff + DAY_W'(1);
                        if (day_wrap) begin
                           month_in = month_wrap ? MONTH_W'(1) : month_ff + MONTH_W'(1);
                           if (month_wrap) begin
                              year_in = year_ff + YEAR_W'(1);
                           end
                        end
                     end
                  end
               end
            end
         end
         KIND_GET: begin
            result.has_result = 1'b1;
         end
         KIND_SET: begin
            result.has_result = 1'b1;
            if (set_ok) begin
               year_in   = item.set_year_offset;
               month_in  = item.set_month[MONTH_W-1:0];
               day_in    = item.set_day[DAY_W-1:0];
               hour_in   = item.set_hour[HOUR_W-1:0];
               minute_in = item.set_minute[MINUTE_W-1:0];
               second_in = item.set_second[SECOND_W-1:0];
            end
         end
         default: begin
            result.has_result = 1'b0;
         end
      endcase

      // reports show the time after the item has taken effect
      result.item.report_kind = item.kind;
      result.item.year_offset = year_in;
      result.item.month       = month_in;
      result.item.day         = day_in;
      result.item.hour        = hour_in;
      result.item.minute      = minute_in;
      result.item.second      = second_in;
      result.item.set_ok      = (item.kind == KIND_SET) && set_ok;
      result.item.interrupt   = (item.kind == KIND_TICK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= '0;
         month_ff  <= MONTH_W'(1);
         day_ff    <= DAY_W'(1);
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         milli_ff  <= '0;
         pcount_ff <= '0;
      end else if (go) begin
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         milli_ff  <= milli_in;
         pcount_ff <= pcount_in;
      end
   end
endmodule

@@ hdl/calendar_real_time_clock.sv @@
// Top level of the calendar real-time clock: input register, time core,
// result register and period register. Depends on crtc_pkg, crtc_channels,
// crtc_time_core.
//
//   channel   dir   role      payload
//   req_chan  in    sink      kind, set_year_offset .. set_second
//   rsp_chan  out   source    report_kind, date, time, set_ok, interrupt
//   csr_chan  in    sink      interrupt_period_ms (always ready)
//
// Throughput is one item per cycle while rsp is not stalled; an item waits in the
// input register, where the time core updates the state, and its result is
// loaded into the result register as the item leaves the input register.
// The only feedback is the time core's state update, registered as the item advances.
// Reset (synchronous) sets the date to the base year, January 1st, 00:00:00,
// and the interrupt period to 1000 ms.
// A stalled rsp holds its result; the input register still advances items
// that produce no result, and req_ready drops only when a pending result
// cannot move into a full, stalled result register.
module calendar_real_time_clock import crtc_pkg::*; #(
   parameter int YEAR_BASE = YEAR_BASE_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   crtc_req_if.sink   req_chan,
   crtc_rsp_if.source rsp_chan,
   crtc_csr_if.sink   csr_chan
);
   logic                in_valid_ff, in_valid_in;
   req_item_type        in_item_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_item_type        out_item_ff;
   logic [PERIOD_W-1:0] period_ff;

   core_out_type        core_out;
   logic                out_free;
   logic                advance;
   logic                req_xfer;

   crtc_time_core #(
      .YEAR_BASE (YEAR_BASE)
   ) u_time_core (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .item   (in_item_ff),
      .period (period_ff),
      .result (core_out)
   );

   // the held item moves on when its result, if any, has a slot
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!core_out.has_result || out_free);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = (advance && core_out.has_result) ? 1'b1
                       : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            period_ff <= csr_chan.interrupt_period_ms;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.kind            <= req_chan.kind;
         in_item_ff.set_year_offset <= req_chan.set_year_offset;
         in_item_ff.set_month       <= req_chan.set_month;
         in_item_ff.set_day         <= req_chan.set_day;
         in_item_ff.set_hour        <= req_chan.set_hour;
         in_item_ff.set_minute      <= req_chan.set_minute;
         in_item_ff.set_second      <= req_chan.set_second;
      end
      if (advance && core_out.has_result) begin
         out_item_ff <= core_out.item;
      end
   end

   assign csr_chan.ready       = 1'b1;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.report_kind = out_item_ff.report_kind;
   assign rsp_chan.year_offset = out_item_ff.year_offset;
   assign rsp_chan.month       = out_item_ff.month;
   assign rsp_chan.day         = out_item_ff.day;
   assign rsp_chan.hour        = out_item_ff.hour;
   assign rsp_chan.minute      = out_item_ff.minute;
   assign rsp_chan.second      = out_item_ff.second;
   assign rsp_chan.set_ok      = out_item_ff.set_ok;
   assign rsp_chan.interrupt   = out_item_ff.interrupt;
endmodule

@@ hdl/crtc_checker.sv @@
// Port-level checks of the calendar real-time clock result channel, bound
// to the top level. Depends on crtc_pkg.
module crtc_checker import crtc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [KIND_W-1:0]   rsp_report_kind,
   input logic [MONTH_W-1:0]  rsp_month,
   input logic [DAY_W-1:0]    rsp_day,
   input logic [HOUR_W-1:0]   rsp_hour,
   input logic [MINUTE_W-1:0] rsp_minute,
   input logic [SECOND_W-1:0] rsp_second,
   input logic                rsp_set_ok,
   input logic                rsp_interrupt
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_report_kind) && $stable(rsp_second)
         && $stable(rsp_set_ok) && $stable(rsp_interrupt))
      else $error("rsp payload changed while stalled");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= MONTH_W'(1) && rsp_month <= MONTH_W'(MONTHS)
         && rsp_day >= DAY_W'(1) && rsp_hour < HOUR_W'(HOURS)
         && rsp_minute < MINUTE_W'(MINUTES) && rsp_second < SECOND_W'(SECONDS))
      else $error("reported date or time out of range");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_interrupt == (rsp_report_kind == REPORT_PERIODIC))
         && (!rsp_set_ok || rsp_report_kind == REPORT_SET))
      else $error("flags disagree with report kind");
endmodule

bind calendar_real_time_clock crtc_checker u_crtc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_report_kind (rsp_chan.report_kind),
   .rsp_month       (rsp_chan.month),
   .rsp_day         (rsp_chan.day),
   .rsp_hour        (rsp_chan.hour),
   .rsp_minute      (rsp_chan.minute),
   .rsp_second      (rsp_chan.second),
   .rsp_set_ok      (rsp_chan.set_ok),
   .rsp_interrupt   (rsp_chan.interrupt)
);
